### rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property must never hold outside reset.
`define RPA_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

### rtl/rpa_pkg.sv
// Types and constants of the reference-counted page allocator.
package rpa_pkg;

  localparam int unsigned PAGE_W   = 15;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned REF_W    = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 3'd0,
    OP_FREE     = 3'd1,
    OP_ADD_REF  = 3'd2,
    OP_READ_REF = 3'd3,
    OP_ADD_PAGE = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_INVALID = 2'd2,
    STS_IGNORED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page_out;
    logic [REF_W-1:0]    ref_count;
    logic                page_released;
  } rsp_t;

  typedef struct packed {
    logic              rd;
    logic              pop;
    logic              push;
    logic [PAGE_W-1:0] page;
  } stack_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stack_stat_t;

endpackage

### rtl/rpa_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module rpa_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### rtl/rpa_free_stack.sv
// LIFO free-page stack: top pointer over a synchronous RAM.
module rpa_free_stack #(
  parameter int unsigned NUM_PAGES = 32768
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rpa_pkg::stack_req_t        req_i,
  output rpa_pkg::stack_stat_t       stat_o,
  output logic [rpa_pkg::PAGE_W-1:0] rd_page_o
);

  localparam int unsigned AW = $clog2(NUM_PAGES);
  localparam int unsigned TW = $clog2(NUM_PAGES + 1);

  logic [TW-1:0] top_q, top_d;
  logic [TW-1:0] top_m1;

  assign top_m1       = top_q - TW'(1);
  assign stat_o.empty = (top_q == '0);
  assign stat_o.full  = (top_q == TW'(NUM_PAGES));

  always_comb begin
    top_d = top_q;
    if (req_i.pop && !stat_o.empty) begin
      top_d = top_m1;
    end else if (req_i.push && !stat_o.full) begin
      top_d = top_q + TW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
    end else begin
      top_q <= top_d;
    end
  end

  rpa_ram #(
    .DEPTH(NUM_PAGES),
    .WIDTH(rpa_pkg::PAGE_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.push && !stat_o.full),
    .waddr_i(top_q[AW-1:0]),
    .wdata_i(req_i.page),
    .re_i   (req_i.rd),
    .raddr_i(top_m1[AW-1:0]),
    .rdata_o(rd_page_o)
  );

endmodule

### rtl/refcounted_page_allocator_core.sv
// Reference-counted page allocator top level: control, count memory and free stack.
// One request is accepted when start is high and busy is low; its result appears on
// rsp_o with result_strobe_o high for exactly one cycle after the EXEC state, as both
// are registered, and the receiver cannot stall it. busy stays high in the EXEC state
// after each request while the count memory does its read-modify-write, so no request
// is taken until it ends. After reset the count memory is cleared one entry a cycle
// with busy high until all entries are cleared; cfg_we_i writes are taken at any time.
module refcounted_page_allocator_core #(
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  rpa_pkg::req_t              req_i,
  output logic                       result_strobe_o,
  output rpa_pkg::rsp_t              rsp_o,
  input  logic                       cfg_we_i,
  input  logic [rpa_pkg::PAGE_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW   = $clog2(NUM_PAGES);
  localparam int unsigned CMPW = (AW > rpa_pkg::PAGE_W) ? AW + 1 : rpa_pkg::PAGE_W + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  rpa_pkg::state_e state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [rpa_pkg::PAGE_W-1:0] cfg_q;
  logic [rpa_pkg::OP_W-1:0]   op_q, op_d;
  logic [rpa_pkg::PAGE_W-1:0] page_q, page_d;
  rpa_pkg::rsp_t   rsp_q, rsp_d;
  logic            strobe_q, strobe_d;

  logic                  cnt_we, cnt_re;
  logic [AW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata, cnt_res;
  logic                  in_store, page_ok;

  rpa_pkg::stack_req_t        stk_req;
  rpa_pkg::stack_stat_t       stk_stat;
  logic [rpa_pkg::PAGE_W-1:0] stk_page;

  assign in_store = CMPW'(page_q) < CMPW'(NUM_PAGES);
  assign page_ok  = in_store && (page_q >= cfg_q);
  assign busy     = (state_q != rpa_pkg::ST_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    op_d      = op_q;
    page_d    = page_q;
    rsp_d     = rsp_q;
    strobe_d  = 1'b0;
    cnt_we    = 1'b0;
    cnt_re    = 1'b0;
    cnt_waddr = AW'(page_q);
    cnt_wdata = '0;
    cnt_res   = '0;
    stk_req   = '0;
    stk_req.page = page_q;
    case (state_q)
      rpa_pkg::ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(NUM_PAGES - 1)) begin
          state_d = rpa_pkg::ST_IDLE;
        end
      end
      rpa_pkg::ST_IDLE: begin
        if (start) begin
          op_d    = req_i.operation;
          page_d  = req_i.page_number;
          cnt_re  = 1'b1;
          stk_req.rd = (req_i.operation == rpa_pkg::OP_ALLOC) && !stk_stat.empty;
          state_d = rpa_pkg::ST_EXEC;
        end
      end
      rpa_pkg::ST_EXEC: begin
        state_d  = rpa_pkg::ST_IDLE;
        strobe_d = 1'b1;
        rsp_d.status        = rpa_pkg::STS_OK;
        rsp_d.page_out      = page_q;
        rsp_d.page_released = 1'b0;
        case (op_q)
          rpa_pkg::OP_ALLOC: begin
            if (stk_stat.empty) begin
              rsp_d.status   = rpa_pkg::STS_NO_FREE;
              rsp_d.page_out = '0;
            end else begin
              stk_req.pop    = 1'b1;
              rsp_d.page_out = stk_page;
              cnt_we         = 1'b1;
              cnt_waddr      = AW'(stk_page);
              cnt_wdata      = COUNT_BITS'(1);
              cnt_res        = COUNT_BITS'(1);
            end
          end
          rpa_pkg::OP_FREE: begin
            if (!page_ok) begin
              rsp_d.status = rpa_pkg::STS_INVALID;
              cnt_res      = in_store ? cnt_rdata : '0;
            end else if (cnt_rdata == '0) begin
              rsp_d.status = rpa_pkg::STS_IGNORED;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rdata - COUNT_BITS'(1);
              cnt_res   = cnt_wdata;
              if (cnt_wdata == '0 && !stk_stat.full) begin
                stk_req.push        = 1'b1;
                rsp_d.page_released = 1'b1;
              end
            end
          end
          rpa_pkg::OP_ADD_REF: begin
            if (!page_ok) begin
              rsp_d.status = rpa_pkg::STS_IGNORED;
              cnt_res      = in_store ? cnt_rdata : '0;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = (cnt_rdata == COUNT_MAX) ? cnt_rdata
                                                   : cnt_rdata + COUNT_BITS'(1);
              cnt_res   = cnt_wdata;
            end
          end
          rpa_pkg::OP_READ_REF: begin
            if (!in_store) begin
              rsp_d.status = rpa_pkg::STS_INVALID;
            end else begin
              cnt_res = cnt_rdata;
            end
          end
          rpa_pkg::OP_ADD_PAGE: begin
            if (!page_ok) begin
              rsp_d.status = rpa_pkg::STS_INVALID;
              cnt_res      = in_store ? cnt_rdata : '0;
            end else begin
              cnt_we = 1'b1;
              if (!stk_stat.full) begin
                stk_req.push        = 1'b1;
                rsp_d.page_released = 1'b1;
              end
            end
          end
          default: begin
            rsp_d.status = rpa_pkg::STS_IGNORED;
          end
        endcase
        rsp_d.ref_count = rpa_pkg::REF_W'(cnt_res);
      end
      default: begin
        state_d = rpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rpa_pkg::ST_CLEAR;
      clr_q    <= '0;
      cfg_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      strobe_q <= strobe_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    page_q <= page_d;
    rsp_q  <= rsp_d;
  end

  assign result_strobe_o = strobe_q;
  assign rsp_o           = rsp_q;

  rpa_ram #(
    .DEPTH(NUM_PAGES),
    .WIDTH(COUNT_BITS)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .re_i   (cnt_re),
    .raddr_i(AW'(req_i.page_number)),
    .rdata_o(cnt_rdata)
  );

  rpa_free_stack #(
    .NUM_PAGES(NUM_PAGES)
  ) u_free_stack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (stk_req),
    .stat_o   (stk_stat),
    .rd_page_o(stk_page)
  );

endmodule

### rtl/rpa_checker.sv
// Port-level checks of the page allocator and their bind to the top level.
`include "assert_macros.svh"

module rpa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          result_strobe_o,
  input rpa_pkg::rsp_t rsp_o
);

  `RPA_ASSERT(a_req_gets_result, clk_i, rst_ni, (start && !busy) |-> ##2 result_strobe_o, "request without result")
  `RPA_ASSERT(a_req_goes_busy, clk_i, rst_ni, (start && !busy) |=> busy, "busy not raised after request")
  `RPA_ASSERT_NEVER(a_strobe_back_to_back, clk_i, rst_ni, result_strobe_o && $past(result_strobe_o), "two results in a row")
  `RPA_ASSERT(a_no_free_empty, clk_i, rst_ni, (result_strobe_o && rsp_o.status == rpa_pkg::STS_NO_FREE) |-> (rsp_o.page_out == '0 && rsp_o.ref_count == '0 && !rsp_o.page_released), "no-free result carries data")

endmodule

bind refcounted_page_allocator_core rpa_checker u_rpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_strobe_o(result_strobe_o),
  .rsp_o          (rsp_o)
);

### verif/testbench.sv
// Self-checking testbench for the reference-counted page allocator core.
module testbench;

  localparam int unsigned NUM_PAGES = 32768;
  localparam int unsigned COUNT_BITS = 16;
  localparam logic [rpa_pkg::REF_W-1:0] COUNT_MAX = '1;
  localparam logic [rpa_pkg::OP_W-1:0] OP_FIRST_UNDEFINED = 3'd5;
  localparam int unsigned LAST_PAGE = NUM_PAGES - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  rpa_pkg::req_t req_i = '0;
  logic result_strobe_o;
  rpa_pkg::rsp_t rsp_o;
  logic cfg_we_i = 1'b0;
  logic [rpa_pkg::PAGE_W-1:0] cfg_wdata_i = '0;

  refcounted_page_allocator_core #(
    .NUM_PAGES (NUM_PAGES),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_strobe_o(result_strobe_o),
    .rsp_o          (rsp_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // allocator shadow state
  logic [rpa_pkg::REF_W-1:0]  page_counts [NUM_PAGES];
  logic [rpa_pkg::PAGE_W-1:0] free_pages [NUM_PAGES];
  int unsigned                free_depth = 0;
  logic [rpa_pkg::PAGE_W-1:0] usable_floor = '0;

  rpa_pkg::req_t pending_reqs[$];
  rpa_pkg::rsp_t expected_rsps[$];
  int   queued_count = 0;
  int   accepted_count = 0;
  int   checked_count = 0;
  int   fail_count = 0;
  int   floor_writes = 0;
  bit   req_taken = 1'b0;
  bit   gaps_on = 1'b1;
  int   gap_left = 0;
  int   burst_left = 0;

  function automatic bit release_page(input logic [rpa_pkg::PAGE_W-1:0] p);
    page_counts[p] = page_counts[p] - 1'b1;
    if (page_counts[p] == '0 && free_depth < NUM_PAGES) begin
      free_pages[free_depth] = p;
      free_depth++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic rpa_pkg::rsp_t predict_alloc_step(input rpa_pkg::req_t r);
    rpa_pkg::rsp_t o;
    logic [rpa_pkg::PAGE_W-1:0] p;
    bit usable;
    p = r.page_number;
    usable = (p >= usable_floor);
    o.status = rpa_pkg::STS_OK;
    o.page_out = p;
    o.ref_count = '0;
    o.page_released = 1'b0;
    case (r.operation)
      rpa_pkg::OP_ALLOC: begin
        if (free_depth == 0) begin
          o.status = rpa_pkg::STS_NO_FREE;
          o.page_out = '0;
        end else begin
          free_depth--;
          o.page_out = free_pages[free_depth];
          page_counts[o.page_out] = rpa_pkg::REF_W'(1);
          o.ref_count = rpa_pkg::REF_W'(1);
        end
      end
      rpa_pkg::OP_FREE: begin
        if (!usable) begin
          o.status = rpa_pkg::STS_INVALID;
          o.ref_count = page_counts[p];
        end else if (page_counts[p] == '0) begin
          o.status = rpa_pkg::STS_IGNORED;
        end else begin
          o.page_released = release_page(p);
          o.ref_count = page_counts[p];
        end
      end
      rpa_pkg::OP_ADD_REF: begin
        if (!usable) begin
          o.status = rpa_pkg::STS_IGNORED;
        end else if (page_counts[p] < COUNT_MAX) begin
          page_counts[p] = page_counts[p] + 1'b1;
        end
        o.ref_count = page_counts[p];
      end
      rpa_pkg::OP_READ_REF: o.ref_count = page_counts[p];
      rpa_pkg::OP_ADD_PAGE: begin
        if (!usable) begin
          o.status = rpa_pkg::STS_INVALID;
        end else begin
          page_counts[p] = rpa_pkg::REF_W'(1);
          o.page_released = release_page(p);
        end
        o.ref_count = page_counts[p];
      end
      default: o.status = rpa_pkg::STS_IGNORED;
    endcase
    return o;
  endfunction

  function automatic int draw_request_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (roll < 4) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 60) return $urandom_range(0, 2);
    if (roll < 90) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk_i) begin : drive_requests
    logic next_start;
    rpa_pkg::req_t next_req;
    next_start = start;
    next_req = req_i;
    if (start && req_taken) next_start = 1'b0;
    if (!next_start) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        next_start = 1'b1;
        gap_left = draw_request_gap();
      end
    end
    start <= next_start;
    req_i <= next_req;
  end

  always @(posedge clk_i) begin : check_results
    rpa_pkg::rsp_t want;
    if (!rst_ni) begin
      req_taken = 1'b0;
    end else begin
      if (cfg_we_i) usable_floor = cfg_wdata_i;
      if (result_strobe_o) begin
        if (expected_rsps.size() == 0) begin
          $error("result with no request outstanding: %p", rsp_o);
          fail_count++;
        end else begin
          want = expected_rsps.pop_front();
          checked_count++;
          if (rsp_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_o.status);
            fail_count++;
          end
          if (rsp_o.page_out !== want.page_out) begin
            $error("page_out: expected %0d, got %0d", want.page_out, rsp_o.page_out);
            fail_count++;
          end
          if (rsp_o.ref_count !== want.ref_count) begin
            $error("ref_count: expected %0d, got %0d", want.ref_count, rsp_o.ref_count);
            fail_count++;
          end
          if (rsp_o.page_released !== want.page_released) begin
            $error("page_released: expected %0d, got %0d",
                   want.page_released, rsp_o.page_released);
            fail_count++;
          end
        end
      end
      req_taken = start && !busy;
      if (req_taken) begin
        accepted_count++;
        expected_rsps.push_back(predict_alloc_step(req_i));
      end
    end
  end

  task automatic queue_request(input logic [rpa_pkg::OP_W-1:0] op, input int unsigned page);
    pending_reqs.push_back(rpa_pkg::req_t'{operation: op,
                                           page_number: rpa_pkg::PAGE_W'(page)});
    queued_count++;
  endtask

  task automatic drain_requests();
    while (accepted_count != queued_count || expected_rsps.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_usable_floor(input int unsigned value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= rpa_pkg::PAGE_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    floor_writes++;
  endtask

  // mostly pages just above the floor so alloc/free/add_ref collide
  function automatic int unsigned pick_page(input int unsigned floor_val);
    int roll;
    int unsigned p;
    roll = $urandom_range(0, 99);
    if (roll < 70 || (roll < 80 && floor_val == 0)) begin
      p = floor_val + $urandom_range(0, 7);
      return (p > LAST_PAGE) ? LAST_PAGE : p;
    end
    if (roll < 80) return floor_val - $urandom_range(1, (floor_val < 3) ? floor_val : 3);
    return $urandom_range(0, LAST_PAGE);
  endfunction

  task automatic queue_random_phase(input int unsigned floor_val, input int count);
    int roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) queue_request(rpa_pkg::OP_ALLOC, $urandom_range(0, LAST_PAGE));
      else if (roll < 50) queue_request(rpa_pkg::OP_FREE, pick_page(floor_val));
      else if (roll < 68) queue_request(rpa_pkg::OP_ADD_REF, pick_page(floor_val));
      else if (roll < 78) queue_request(rpa_pkg::OP_READ_REF, pick_page(floor_val));
      else if (roll < 95) queue_request(rpa_pkg::OP_ADD_PAGE, pick_page(floor_val));
      else queue_request(OP_FIRST_UNDEFINED + rpa_pkg::OP_W'($urandom_range(0, 2)),
                         $urandom_range(0, LAST_PAGE));
    end
  endtask

  initial begin : stimulus
    int unsigned floors [5];
    for (int i = 0; i < NUM_PAGES; i++) begin
      page_counts[i] = '0;
      free_pages[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_usable_floor(0);

    queue_request(rpa_pkg::OP_ALLOC, 0);
    queue_request(rpa_pkg::OP_READ_REF, 0);
    queue_request(rpa_pkg::OP_READ_REF, LAST_PAGE);
    queue_request(rpa_pkg::OP_ADD_PAGE, 0);
    queue_request(rpa_pkg::OP_ADD_PAGE, LAST_PAGE);
    queue_request(rpa_pkg::OP_ALLOC, 0);
    queue_request(rpa_pkg::OP_ALLOC, LAST_PAGE);
    queue_request(rpa_pkg::OP_ALLOC, 0);
    queue_request(rpa_pkg::OP_ADD_REF, 21);
    queue_request(rpa_pkg::OP_ADD_REF, 21);
    queue_request(rpa_pkg::OP_FREE, 21);
    queue_request(rpa_pkg::OP_FREE, 21);
    queue_request(rpa_pkg::OP_FREE, 21);
    queue_request(rpa_pkg::OP_ADD_PAGE, 21);
    queue_request(rpa_pkg::OP_ADD_PAGE, 21);
    queue_request(rpa_pkg::OP_ALLOC, 0);
    queue_request(rpa_pkg::OP_ADD_REF, 21);
    queue_request(rpa_pkg::OP_ALLOC, 0);
    queue_request(OP_FIRST_UNDEFINED, 15'h5555);
    queue_request(OP_FIRST_UNDEFINED + 3'd1, 15'h2AAA);
    queue_request(OP_FIRST_UNDEFINED + 3'd2, LAST_PAGE);
    drain_requests();

    // pages below the floor, at it and above it
    write_usable_floor(100);
    queue_request(rpa_pkg::OP_FREE, 99);
    queue_request(rpa_pkg::OP_ADD_REF, 99);
    queue_request(rpa_pkg::OP_ADD_PAGE, 99);
    queue_request(rpa_pkg::OP_READ_REF, 99);
    queue_request(rpa_pkg::OP_ADD_PAGE, 100);
    queue_request(rpa_pkg::OP_FREE, LAST_PAGE);
    queue_request(rpa_pkg::OP_ALLOC, 0);
    drain_requests();

    floors = '{0, 1, LAST_PAGE, $urandom_range(2, LAST_PAGE - 1), 100};
    foreach (floors[i]) begin
      // one phase runs back to back
      gaps_on = (i != 1);
      write_usable_floor(floors[i]);
      queue_random_phase(floors[i], 300);
      drain_requests();
    end

    $display("Checked %0d results across %0d floor settings: directed edge cases",
             checked_count, floor_writes);
    $display("and random ops with idle gaps, plus one back-to-back phase.");
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #30000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### refcounted_page_allocator_core.f
+incdir+rtl
rtl/rpa_pkg.sv
rtl/rpa_ram.sv
rtl/rpa_free_stack.sv
rtl/refcounted_page_allocator_core.sv
rtl/rpa_checker.sv
verif/testbench.sv
